FILE: hdl/command_line_tokenizer_unit_assert.svh
// Assertion macros for the command line tokenizer unit.
`ifndef COMMAND_LINE_TOKENIZER_UNIT_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CLTU_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CLTU_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cltu_pkg.sv
// Types, constants and per-byte tokenizing functions of the command line tokenizer.
package cltu_pkg;

  localparam int ARG_SLOTS      = 64;
  localparam int STAGE_SLOTS    = 8;
  localparam int PIPELINE_SLOTS = 8;

  localparam int MAX_RES    = 3;
  localparam int RES_CW     = $clog2(MAX_RES + 1);
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;

  localparam int ARGC_W = 7;
  localparam int STGC_W = 4;
  localparam int PLC_W  = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  localparam logic [1:0] CFG_IDX_ARG      = 2'd0;
  localparam logic [1:0] CFG_IDX_STAGE    = 2'd1;
  localparam logic [1:0] CFG_IDX_PIPELINE = 2'd2;

  typedef enum logic [3:0] {
    KIND_WORD_BYTE  = 4'd0,
    KIND_WORD_END   = 4'd1,
    KIND_PIPE       = 4'd2,
    KIND_AND        = 4'd3,
    KIND_OR         = 4'd4,
    KIND_SEQ        = 4'd5,
    KIND_IN         = 4'd6,
    KIND_OUT        = 4'd7,
    KIND_APPEND     = 4'd8,
    KIND_LINE_DONE  = 4'd9,
    KIND_ERROR      = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_ARGS       = 3'd1,
    ERR_EMPTY_PIPE = 3'd2,
    ERR_STAGES     = 3'd3,
    ERR_EMPTY_OP   = 3'd4,
    ERR_PIPELINES  = 3'd5,
    ERR_NO_FILE    = 3'd6,
    ERR_LONE_AMP   = 3'd7
  } err_t;

  typedef enum logic [1:0] {
    ROLE_ARG    = 2'd0,
    ROLE_IN     = 2'd1,
    ROLE_OUT    = 2'd2,
    ROLE_APPEND = 2'd3
  } role_t;

  typedef enum logic [2:0] {
    M_GAP   = 3'd0,
    M_WORD  = 3'd1,
    M_QUOTE = 3'd2,
    M_BAR   = 3'd3,
    M_AMP   = 3'd4,
    M_GT    = 3'd5
  } mode_t;

  typedef struct packed {
    logic [ARGC_W-1:0] arg;
    logic [STGC_W-1:0] stage;
    logic [PLC_W-1:0]  pipe;
  } limits_t;

  typedef struct packed {
    mode_t             mode;
    logic              qdbl;
    role_t             pend;
    logic [ARGC_W-1:0] argc;
    logic [STGC_W-1:0] stgc;
    logic [PLC_W-1:0]  plc;
    logic              first;
    logic              err;
  } tok_state_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch;
    logic [1:0] role;
    logic [2:0] pidx;
    logic [2:0] sidx;
    logic [5:0] aidx;
    logic [2:0] err;
    logic [3:0] pcount;
    logic       last;
  } result_t;

  typedef struct packed {
    tok_state_t                st;
    logic [RES_CW-1:0]         n;
    result_t [MAX_RES-1:0]     res;
  } step_t;

  localparam tok_state_t STATE_RESET = '{
    mode: M_GAP, qdbl: 1'b0, pend: ROLE_ARG, argc: '0,
    stgc: STGC_W'(1), plc: PLC_W'(1), first: 1'b0, err: 1'b0
  };

  function automatic limits_t eff_limits(logic [ARGC_W-1:0] a, logic [STGC_W-1:0] s,
                                         logic [PLC_W-1:0] p);
    limits_t l;
    l.arg   = (int'(a) < ARG_SLOTS)      ? a : ARGC_W'(ARG_SLOTS);
    l.stage = (int'(s) < STAGE_SLOTS)    ? s : STGC_W'(STAGE_SLOTS);
    l.pipe  = (int'(p) < PIPELINE_SLOTS) ? p : PLC_W'(PIPELINE_SLOTS);
    return l;
  endfunction

  function automatic logic is_sep(logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR);
  endfunction

  function automatic logic is_op(logic [7:0] ch);
    return (ch == CH_BAR) || (ch == CH_LT) || (ch == CH_GT) || (ch == CH_SEMI) ||
           (ch == CH_AMP);
  endfunction

  function automatic logic is_quote(logic [7:0] ch);
    return (ch == CH_DQ) || (ch == CH_SQ);
  endfunction

  // Append one result tagged with the current pipeline and stage; drop past MAX_RES.
  function automatic step_t put(step_t c, kind_t kind, logic [7:0] ch, role_t role,
                                logic [5:0] ai, err_t code, logic [3:0] pc);
    step_t r;
    r = c;
    if (int'(c.n) < MAX_RES) begin
      r.res[c.n] = '{kind: kind, ch: ch, role: role,
                     pidx: 3'(c.st.plc - PLC_W'(1)), sidx: 3'(c.st.stgc - STGC_W'(1)),
                     aidx: ai, err: code, pcount: pc, last: 1'b0};
      r.n = c.n + RES_CW'(1);
    end
    return r;
  endfunction

  function automatic step_t fail(step_t c, err_t code);
    step_t r;
    r = put(c, KIND_ERROR, 8'd0, ROLE_ARG, 6'd0, code, 4'd0);
    r.st.err  = 1'b1;
    r.st.mode = M_GAP;
    return r;
  endfunction

  function automatic step_t word_byte(step_t c, logic [7:0] ch);
    return put(c, KIND_WORD_BYTE, ch, c.st.pend,
               (c.st.pend == ROLE_ARG) ? c.st.argc[5:0] : 6'd0, ERR_NONE, 4'd0);
  endfunction

  function automatic step_t word_end(step_t c);
    step_t r;
    r = put(c, KIND_WORD_END, 8'd0, c.st.pend,
            (c.st.pend == ROLE_ARG) ? c.st.argc[5:0] : 6'd0, ERR_NONE, 4'd0);
    if (c.st.pend == ROLE_ARG) begin
      if (c.st.stgc == STGC_W'(1)) begin
        r.st.first = 1'b1;
      end
      r.st.argc = c.st.argc + ARGC_W'(1);
    end
    r.st.pend = ROLE_ARG;
    r.st.mode = M_GAP;
    return r;
  endfunction

  function automatic step_t do_pipe(step_t c, limits_t l);
    step_t r;
    r = c;
    r.st.mode = M_GAP;
    if (r.st.pend != ROLE_ARG) begin
      r = fail(r, ERR_NO_FILE);
    end else if (r.st.argc == '0) begin
      r = fail(r, ERR_EMPTY_PIPE);
    end else if (r.st.stgc >= l.stage) begin
      r = fail(r, ERR_STAGES);
    end else begin
      r = put(r, KIND_PIPE, 8'd0, ROLE_ARG, 6'd0, ERR_NONE, 4'd0);
      r.st.stgc = r.st.stgc + STGC_W'(1);
      r.st.argc = '0;
    end
    return r;
  endfunction

  function automatic step_t do_join(step_t c, limits_t l, kind_t kind);
    step_t r;
    r = c;
    r.st.mode = M_GAP;
    if (r.st.pend != ROLE_ARG) begin
      r = fail(r, ERR_NO_FILE);
    end else if (r.st.argc == '0) begin
      r = fail(r, ERR_EMPTY_OP);
    end else if (r.st.plc >= l.pipe) begin
      r = fail(r, ERR_PIPELINES);
    end else begin
      r = put(r, kind, 8'd0, ROLE_ARG, 6'd0, ERR_NONE, 4'd0);
      r.st.plc   = r.st.plc + PLC_W'(1);
      r.st.stgc  = STGC_W'(1);
      r.st.argc  = '0;
      r.st.first = 1'b0;
    end
    return r;
  endfunction

  function automatic step_t do_redir(step_t c, role_t role, kind_t kind);
    step_t r;
    r = c;
    r.st.mode = M_GAP;
    if (r.st.pend != ROLE_ARG) begin
      r = fail(r, ERR_NO_FILE);
    end else begin
      r = put(r, kind, 8'd0, ROLE_ARG, 6'd0, ERR_NONE, 4'd0);
      r.st.pend = role;
    end
    return r;
  endfunction

  function automatic step_t gap_byte(step_t c, limits_t l, logic [7:0] ch);
    step_t r;
    r = c;
    r.st.mode = M_GAP;
    if (is_sep(ch)) begin
      r.st.mode = M_GAP;
    end else if (ch == CH_BAR) begin
      r.st.mode = M_BAR;
    end else if (ch == CH_AMP) begin
      r.st.mode = M_AMP;
    end else if (ch == CH_GT) begin
      r.st.mode = M_GT;
    end else if (ch == CH_LT) begin
      r = do_redir(r, ROLE_IN, KIND_IN);
    end else if (ch == CH_SEMI) begin
      r = do_join(r, l, KIND_SEQ);
    end else if ((r.st.pend == ROLE_ARG) && (r.st.argc >= l.arg)) begin
      r = fail(r, ERR_ARGS);
    end else if (is_quote(ch)) begin
      r.st.mode = M_QUOTE;
      r.st.qdbl = (ch == CH_DQ);
    end else begin
      r = word_byte(r, ch);
      r.st.mode = M_WORD;
    end
    return r;
  endfunction

  function automatic step_t take_byte(step_t c, limits_t l, logic [7:0] ch);
    step_t r;
    r = c;
    case (c.st.mode)
      M_WORD: begin
        if (is_sep(ch)) begin
          r = word_end(c);
        end else if (is_op(ch)) begin
          r = word_end(c);
          r = gap_byte(r, l, ch);
        end else if (is_quote(ch)) begin
          r.st.mode = M_QUOTE;
          r.st.qdbl = (ch == CH_DQ);
        end else begin
          r = word_byte(c, ch);
        end
      end
      M_QUOTE: begin
        if (ch == (c.st.qdbl ? CH_DQ : CH_SQ)) begin
          r.st.mode = M_WORD;
        end else begin
          r = word_byte(c, ch);
        end
      end
      M_BAR: begin
        if (ch == CH_BAR) begin
          r = do_join(c, l, KIND_OR);
        end else begin
          r = do_pipe(c, l);
          if (!r.st.err) begin
            r = gap_byte(r, l, ch);
          end
        end
      end
      M_AMP: begin
        r.st.mode = M_GAP;
        if (ch == CH_AMP) begin
          r = do_join(r, l, KIND_AND);
        end else begin
          r = fail(r, ERR_LONE_AMP);
        end
      end
      M_GT: begin
        if (ch == CH_GT) begin
          r = do_redir(c, ROLE_APPEND, KIND_APPEND);
        end else begin
          r = do_redir(c, ROLE_OUT, KIND_OUT);
          if (!r.st.err) begin
            r = gap_byte(r, l, ch);
          end
        end
      end
      default: begin
        r = gap_byte(c, l, ch);
      end
    endcase
    return r;
  endfunction

  function automatic step_t take_end(step_t c, limits_t l);
    step_t            r;
    logic [PLC_W-1:0] pc;
    r = c;
    if (!c.st.err) begin
      case (c.st.mode)
        M_WORD, M_QUOTE: r = word_end(c);
        M_BAR:           r = do_pipe(c, l);
        M_AMP:           r = fail(c, ERR_LONE_AMP);
        M_GT:            r = do_redir(c, ROLE_OUT, KIND_OUT);
        default:         r = c;
      endcase
      if (!r.st.err && (r.st.pend != ROLE_ARG)) begin
        r = fail(r, ERR_NO_FILE);
      end
    end
    if (r.st.err) begin
      pc = '0;
    end else if (r.st.first) begin
      pc = r.st.plc;
    end else begin
      pc = r.st.plc - PLC_W'(1);
    end
    // Back to line start first, so line done carries pipeline and stage zero.
    r.st = STATE_RESET;
    r = put(r, KIND_LINE_DONE, 8'd0, ROLE_ARG, 6'd0, ERR_NONE, pc);
    return r;
  endfunction

  // Full work for one input item: next state plus up to MAX_RES results.
  function automatic step_t tok_step(tok_state_t st, limits_t l, logic [7:0] ch,
                                     logic le);
    step_t r;
    r.st  = st;
    r.n   = '0;
    r.res = '0;
    if (le) begin
      r = take_end(r, l);
    end else if (!st.err) begin
      r = take_byte(r, l, ch);
    end
    if (r.n != '0) begin
      r.res[r.n - RES_CW'(1)].last = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: hdl/command_line_tokenizer_unit.sv
// Command line tokenizer unit: byte stream in, tagged word and operator requests out.
//
// Bytes of a command line enter one per request, and a request with line_end set
// closes the line. Each byte lands in an input register; when the queue has room, a
// single pass of logic works out the tokenizer state and zero to three results, which
// are written together into an 8-entry result queue. Results leave one per cycle from
// the head of that queue while out_ready is high. The unit takes one byte every cycle
// as long as the queue holds five results or fewer, so a stream that mostly makes one
// result per byte runs at one byte per cycle; bytes that make two or three results (an
// operator that closes a word, a line end after a redirection) drain at one result
// per cycle and hold the input back only when the queue holds more than five results.
// With the queue empty, the first result of a byte is presented once the byte has
// passed the input register and been written into the queue. Input ready depends on
// registered state only, never on out_ready. The three limit registers are plain
// writes on cfg_we and take effect on the next byte; write them between lines.
`include "command_line_tokenizer_unit_assert.svh"

module command_line_tokenizer_unit
  import cltu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_req,
  input  logic        in_line_end,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_kind,
  output logic [7:0]  out_char_out,
  output logic [1:0]  out_word_role,
  output logic [2:0]  out_pipeline_index,
  output logic [2:0]  out_stage_index,
  output logic [5:0]  out_arg_index,
  output logic [2:0]  out_error_code,
  output logic [3:0]  out_pipeline_count,
  output logic        out_last
);

  // Limit registers
  logic [ARGC_W-1:0] arg_limit_r;
  logic [STGC_W-1:0] stage_limit_r;
  logic [PLC_W-1:0]  pipeline_limit_r;
  limits_t           lim;

  // Input register
  logic              in_vld_r;
  logic [7:0]        in_byte_r;
  logic              in_le_r;
  logic              in_take;

  // Tokenizer state
  tok_state_t        st_r;
  tok_state_t        st_nxt;
  step_t             stp;
  logic              can_proc;
  logic              proc;

  // Result queue
  result_t           fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              deq;
  result_t           head;

  // Check terms
  logic              q_ptrs_ok;
  logic              counts_ok;
  logic              le_proc;

  // Clamp each limit register to its slot count.
  assign lim = eff_limits(arg_limit_r, stage_limit_r, pipeline_limit_r);

  // Process the held byte only when the queue has room for a full burst.
  assign can_proc = (cnt_r <= CNT_W'(FIFO_DEPTH - MAX_RES));
  assign proc     = in_vld_r && can_proc;
  assign in_ready = !in_vld_r || can_proc;
  assign in_take  = in_valid && in_ready;

  // One pass over the held byte: next state and the results it causes.
  assign stp    = tok_step(st_r, lim, in_byte_r, in_le_r);
  assign st_nxt = proc ? stp.st : st_r;

  // Queue bookkeeping: enqueue the burst, pop the head on each output request.
  assign out_valid  = (cnt_r != '0);
  assign deq        = out_valid && out_ready;
  assign wr_ptr_nxt = proc ? (wr_ptr_r + FIFO_AW'(stp.n)) : wr_ptr_r;
  assign rd_ptr_nxt = deq ? (rd_ptr_r + FIFO_AW'(1)) : rd_ptr_r;
  assign cnt_nxt    = cnt_r + (proc ? CNT_W'(stp.n) : CNT_W'(0)) - CNT_W'(deq);

  assign head               = fifo_mem_r[rd_ptr_r];
  assign out_kind           = head.kind;
  assign out_char_out       = head.ch;
  assign out_word_role      = head.role;
  assign out_pipeline_index = head.pidx;
  assign out_stage_index    = head.sidx;
  assign out_arg_index      = head.aidx;
  assign out_error_code     = head.err;
  assign out_pipeline_count = head.pcount;
  assign out_last           = head.last;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arg_limit_r      <= ARGC_W'(64);
      stage_limit_r    <= STGC_W'(8);
      pipeline_limit_r <= PLC_W'(8);
      in_vld_r         <= 1'b0;
      st_r             <= STATE_RESET;
      wr_ptr_r         <= '0;
      rd_ptr_r         <= '0;
      cnt_r            <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_ARG:      arg_limit_r      <= cfg_wdata;
          CFG_IDX_STAGE:    stage_limit_r    <= cfg_wdata[STGC_W-1:0];
          CFG_IDX_PIPELINE: pipeline_limit_r <= cfg_wdata[PLC_W-1:0];
          default:          ;
        endcase
      end
      // Hold the byte until processed; refill in the same cycle when possible.
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (proc) begin
        in_vld_r <= 1'b0;
      end
      st_r     <= st_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload: input byte and queue entries
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte_req;
      in_le_r   <= in_line_end;
    end
    for (int i = 0; i < MAX_RES; i++) begin
      if (proc && (i < int'(stp.n))) begin
        fifo_mem_r[FIFO_AW'(wr_ptr_r + FIFO_AW'(i))] <= stp.res[i];
      end
    end
  end

  // Checks
  assign q_ptrs_ok = (cnt_r <= CNT_W'(FIFO_DEPTH)) &&
                     (FIFO_AW'(wr_ptr_r - rd_ptr_r) == cnt_r[FIFO_AW-1:0]);
  assign counts_ok = (st_r.stgc != '0) && (st_r.plc != '0) &&
                     (int'(st_r.stgc) <= STAGE_SLOTS) && (int'(st_r.plc) <= PIPELINE_SLOTS);
  assign le_proc   = proc && in_le_r;

  `CLTU_CHECK(a_fifo_ptrs, 1'b1, q_ptrs_ok, "result queue pointers disagree with count")
  `CLTU_CHECK_NEXT(a_line_end_result, le_proc, out_valid, "line end left no result queued")
  `CLTU_CHECK_NEXT(a_line_end_clears, le_proc, st_r == STATE_RESET, "state not cleared")
  `CLTU_CHECK(a_counts_bounded, 1'b1, counts_ok, "stage or pipeline count out of range")

endmodule
